// ===== hw/rtl/polyphonic_sine_note_synth_defines.svh =====
// Assertion macros used by the checker file of the note synthesizer.
`ifndef POLYPHONIC_SINE_NOTE_SYNTH_DEFINES_SVH
`define POLYPHONIC_SINE_NOTE_SYNTH_DEFINES_SVH

// Property that must hold in the cycle after the trigger.
`define PSNS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("psns assertion failed");

// Property that must hold at every clock edge out of reset.
`define PSNS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("psns assertion failed");

`endif

// ===== hw/rtl/psns_pkg.sv =====
// ---------------------------------------------------------------------------
// psns_pkg
// Types, constants and tables of the polyphonic sine note synthesizer.
// ---------------------------------------------------------------------------
`default_nettype none

package psns_pkg;

    localparam int MAX_VOICES_DEF = 20;
    localparam int SAMPLE_RATE    = 8000;
    localparam int PHASE_W        = 13;
    localparam int FREQ_W         = 12;
    localparam int LEN_W          = 20;
    localparam int SAMPLE_W       = 16;
    localparam int QUEUE_DEPTH    = 2;

    // Shared multiplier of the voice engine.
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Reciprocal of the sample rate, scaled by 2^37, rounded up. The phase
    // times this value, shifted right by 20, is floor(phase * 2^17 / rate)
    // exactly for every phase below the rate.
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << 37) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
    localparam logic [MUL_A_W-1:0] PHASE_RECIP = MUL_A_W'(RECIP_FULL);

    localparam logic [LEN_W-1:0] WHOLE_RESET = 20'd32000;

    // Opcodes of the command channel.
    localparam logic [1:0] OP_ADD_KEY = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Register map.
    localparam logic [0:0] REG_WHOLE_NOTE = 1'b0;

    // ASCII digits used by the octave and length codes, and the lower-case range and case shift of the key decode.
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_THREE = 8'h33;
    localparam logic [7:0] CHAR_FOUR  = 8'h34;
    localparam logic [7:0] CHAR_FIVE  = 8'h35;
    localparam logic [7:0] CHAR_SIX   = 8'h36;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_EIGHT = 8'h38;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7a;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    typedef enum logic [1:0] {
        KIND_ADD_KEY,
        KIND_START,
        KIND_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [FREQ_W-1:0]  freq;
        logic               len_valid;
        logic [LEN_W-1:0]   len;
        logic               pause;
    } cmd_entry_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_PHASE,
        BK_QUAD,
        BK_POLY1,
        BK_POLY2,
        BK_POLY3,
        BK_SCALE,
        BK_ACC,
        BK_OUT
    } back_state_t;

    localparam logic [FREQ_W-1:0] PITCH_GRID [0:6][0:12] = '{
        '{12'd33, 12'd35, 12'd37, 12'd39, 12'd41, 12'd44, 12'd46,
          12'd49, 12'd52, 12'd55, 12'd58, 12'd62, 12'd0},
        '{12'd65, 12'd69, 12'd73, 12'd78, 12'd82, 12'd87, 12'd92,
          12'd98, 12'd104, 12'd110, 12'd117, 12'd123, 12'd0},
        '{12'd131, 12'd139, 12'd147, 12'd156, 12'd165, 12'd175, 12'd185,
          12'd196, 12'd208, 12'd220, 12'd233, 12'd247, 12'd0},
        '{12'd262, 12'd277, 12'd294, 12'd311, 12'd330, 12'd349, 12'd370,
          12'd392, 12'd415, 12'd440, 12'd466, 12'd494, 12'd0},
        '{12'd523, 12'd554, 12'd587, 12'd622, 12'd659, 12'd698, 12'd740,
          12'd784, 12'd831, 12'd880, 12'd932, 12'd988, 12'd0},
        '{12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397, 12'd1480,
          12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976, 12'd0},
        '{12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794, 12'd2960,
          12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951, 12'd0}
    };

    // Per-voice amplitude 32767 / voice count, for counts 0 to 32.
    localparam logic [14:0] AMP_TABLE [0:32] = '{
        15'd0, 15'd32767, 15'd16383, 15'd10922, 15'd8191, 15'd6553, 15'd5461,
        15'd4681, 15'd4095, 15'd3640, 15'd3276, 15'd2978, 15'd2730, 15'd2520,
        15'd2340, 15'd2184, 15'd2047, 15'd1927, 15'd1820, 15'd1724, 15'd1638,
        15'd1560, 15'd1489, 15'd1424, 15'd1365, 15'd1310, 15'd1260, 15'd1213,
        15'd1170, 15'd1129, 15'd1092, 15'd1057, 15'd1023
    };

    function automatic logic [3:0] key_column(input logic [7:0] letter);
        logic [7:0] c;
        logic [3:0] col;
        c = letter;
        if (c inside {[CHAR_LOW_A:CHAR_LOW_Z]}) begin
            c = c - CASE_SHIFT;
        end
        case (c)
            "C":     col = 4'd0;
            "X":     col = 4'd1;
            "D":     col = 4'd2;
            "Y":     col = 4'd3;
            "E":     col = 4'd4;
            "F":     col = 4'd5;
            "Z":     col = 4'd6;
            "G":     col = 4'd7;
            "V":     col = 4'd8;
            "A":     col = 4'd9;
            "W":     col = 4'd10;
            "B":     col = 4'd11;
            "P":     col = 4'd12;
            " ":     col = 4'd11;
            default: col = 4'd0;
        endcase
        return col;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/psns_if.sv =====
// ---------------------------------------------------------------------------
// psns_if
// Command and sample channels of the note synthesizer.
// ---------------------------------------------------------------------------
`default_nettype none

interface psns_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] key_letter;
    logic [7:0] octave_digit;
    logic [7:0] length_code;
    logic       same_as_next;

    modport source (output valid, opcode, key_letter, octave_digit, length_code,
                    same_as_next, input ready);
    modport sink (input valid, opcode, key_letter, octave_digit, length_code,
                  same_as_next, output ready);
endinterface

interface psns_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               note_end;

    modport source (output valid, sample, note_end, input ready);
    modport sink (input valid, sample, note_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/psns_front.sv =====
// ---------------------------------------------------------------------------
// psns_front
// Accepts commands, decodes keys and note lengths, and queues them.
// ---------------------------------------------------------------------------
`default_nettype none

module psns_front (
    psns_cmd_if.sink                       cmd,
    input  wire logic [psns_pkg::LEN_W-1:0] whole,
    input  wire logic                      full,
    output logic                           push,
    output psns_pkg::cmd_entry_t           push_entry
);

    logic [2:0]                   row;
    logic [3:0]                   col;
    logic [psns_pkg::LEN_W+1:0]   three_quarter;

    assign cmd.ready = !full;

    always_comb begin
        row = 3'd0;
        if (cmd.octave_digit inside {[psns_pkg::CHAR_ONE:psns_pkg::CHAR_SEVEN]}) begin
            row = 3'(cmd.octave_digit - psns_pkg::CHAR_ONE);
        end
        col = psns_pkg::key_column(cmd.key_letter);
        three_quarter = {2'b00, whole} + {1'b0, whole, 1'b0};

        push_entry.freq      = psns_pkg::PITCH_GRID[row][col];
        push_entry.pause     = cmd.same_as_next;
        push_entry.len_valid = 1'b1;
        push_entry.len       = whole;
        case (cmd.length_code)
            psns_pkg::CHAR_ONE:   push_entry.len = whole;
            psns_pkg::CHAR_TWO:   push_entry.len = three_quarter[psns_pkg::LEN_W+1:2];
            psns_pkg::CHAR_THREE: push_entry.len = whole >> 1;
            psns_pkg::CHAR_FOUR:  push_entry.len = whole >> 2;
            psns_pkg::CHAR_FIVE:  push_entry.len = whole >> 3;
            psns_pkg::CHAR_SIX:   push_entry.len = whole >> 4;
            psns_pkg::CHAR_SEVEN: push_entry.len = whole >> 5;
            psns_pkg::CHAR_EIGHT: push_entry.len = whole >> 6;
            default:              push_entry.len_valid = 1'b0;
        endcase

        push_entry.kind = psns_pkg::KIND_TICK;
        push = 1'b0;
        case (cmd.opcode)
            psns_pkg::OP_ADD_KEY:
            begin
                push_entry.kind = psns_pkg::KIND_ADD_KEY;
                push = cmd.valid && !full;
            end
            psns_pkg::OP_START:
            begin
                push_entry.kind = psns_pkg::KIND_START;
                push = cmd.valid && !full;
            end
            psns_pkg::OP_TICK:
            begin
                push_entry.kind = psns_pkg::KIND_TICK;
                push = cmd.valid && !full;
            end
            // The unused opcode is taken and dropped.
            default: push = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/psns_queue.sv =====
// ---------------------------------------------------------------------------
// psns_queue
// Short command queue between the decoder and the voice engine.
// ---------------------------------------------------------------------------
`default_nettype none

module psns_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire psns_pkg::cmd_entry_t push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      valid,
    output psns_pkg::cmd_entry_t      entry
);

    localparam int PTR_W = (psns_pkg::QUEUE_DEPTH > 1) ? $clog2(psns_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(psns_pkg::QUEUE_DEPTH + 1);

    psns_pkg::cmd_entry_t slot_mem [0:psns_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(psns_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign entry = slot_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(psns_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(psns_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/psns_back.sv =====
// ---------------------------------------------------------------------------
// psns_back
// Voice engine: chord state, note timing and the per-voice sine sum.
// ---------------------------------------------------------------------------
`default_nettype none

module psns_back #(
    parameter int MAX_VOICES = psns_pkg::MAX_VOICES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire psns_pkg::cmd_entry_t       q_entry,
    output logic                            q_pop,
    input  wire logic [psns_pkg::LEN_W-1:0] whole,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [psns_pkg::SAMPLE_W-1:0]   out_sample,
    output logic                            out_end
);

    localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W = $clog2(MAX_VOICES + 1);
    localparam int PW    = psns_pkg::PHASE_W;
    localparam int LW    = psns_pkg::LEN_W;
    localparam int SW    = psns_pkg::SAMPLE_W;

    psns_pkg::back_state_t state_reg, state_next;

    logic [psns_pkg::FREQ_W-1:0] freq_mem [0:MAX_VOICES-1];
    logic [PW-1:0]               phase_reg [0:MAX_VOICES-1];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic              chord_open_reg, chord_open_next;
    logic              note_active_reg, note_active_next;
    logic [LW-1:0]     sample_index_reg, sample_index_next;
    logic [LW-1:0]     note_samples_reg, note_samples_next;
    logic              pause_reg, pause_next;
    logic              silent_reg, silent_next;
    logic [14:0]       amp_reg, amp_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [psns_pkg::PROD_W-1:0] p_reg, p_next;
    logic [15:0]       z_reg, z_next;
    logic [15:0]       z2_reg, z2_next;
    logic [1:0]        quad_reg, quad_next;
    logic              out_valid_reg, out_valid_next;
    logic [SW-1:0]     out_sample_reg, out_sample_next;
    logic              out_end_reg, out_end_next;

    logic [psns_pkg::MUL_A_W-1:0] mul_a;
    logic [psns_pkg::MUL_B_W-1:0] mul_b;
    logic              phase_clear;
    logic              phase_wr;
    logic [PW-1:0]     phase_new;
    logic              freq_wr;
    logic [IDX_W-1:0]  freq_addr;

    logic [CNT_W-1:0]  eff_count;
    logic [LW-1:0]     len_sel;
    logic              last_voice;
    logic              last_sample;
    logic [PW:0]       phase_sum;
    logic [16:0]       quot;
    logic [15:0]       z_off;
    logic [15:0]       t_val;
    logic [16:0]       t_wide;
    logic [14:0]       mag;
    logic [26:0]       idx_scaled;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_end    = out_end_reg;

    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        k_next            = k_reg;
        chord_open_next   = chord_open_reg;
        note_active_next  = note_active_reg;
        sample_index_next = sample_index_reg;
        note_samples_next = note_samples_reg;
        pause_next        = pause_reg;
        silent_next       = silent_reg;
        amp_next          = amp_reg;
        sum_next          = sum_reg;
        z_next            = z_reg;
        z2_next           = z2_reg;
        quad_next         = quad_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_sample_next   = out_sample_reg;
        out_end_next      = out_end_reg;
        q_pop             = 1'b0;
        phase_clear       = 1'b0;
        phase_wr          = 1'b0;
        freq_wr           = 1'b0;
        mul_a             = '0;
        mul_b             = '0;

        eff_count   = chord_open_reg ? count_reg : '0;
        freq_addr   = eff_count[IDX_W-1:0];
        len_sel     = q_entry.len_valid ? q_entry.len : note_samples_reg;
        last_voice  = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
        last_sample = (({1'b0, sample_index_reg} + {{LW{1'b0}}, 1'b1})
                       >= {1'b0, note_samples_reg});
        idx_scaled  = 27'(sample_index_reg) * 27'd125;
        phase_sum   = {1'b0, phase_reg[k_reg]}
                      + (PW+1)'(freq_mem[k_reg]);
        phase_new   = (phase_sum >= (PW+1)'(psns_pkg::SAMPLE_RATE))
                      ? PW'(phase_sum - (PW+1)'(psns_pkg::SAMPLE_RATE))
                      : phase_sum[PW-1:0];
        quot        = p_reg[36:20];
        z_off       = quot[15] ? (16'd32768 - {1'b0, quot[14:0]}) : {1'b0, quot[14:0]};
        t_val       = '0;
        t_wide      = p_reg[31:15];
        mag         = p_reg[29:15];

        case (state_reg)
            psns_pkg::BK_IDLE:
            begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_entry.kind)
                        psns_pkg::KIND_ADD_KEY:
                        begin
                            if (!note_active_reg) begin
                                chord_open_next = 1'b1;
                                count_next      = eff_count;
                                if (eff_count < CNT_W'(MAX_VOICES)) begin
                                    freq_wr    = 1'b1;
                                    count_next = eff_count + CNT_W'(1);
                                end
                            end
                        end
                        psns_pkg::KIND_START:
                        begin
                            note_samples_next = len_sel;
                            pause_next        = q_entry.pause;
                            chord_open_next   = 1'b0;
                            sample_index_next = '0;
                            phase_clear       = 1'b1;
                            note_active_next  = (len_sel != '0);
                        end
                        psns_pkg::KIND_TICK:
                        begin
                            if (note_active_reg) begin
                                k_next      = '0;
                                sum_next    = '0;
                                silent_next = pause_reg && (idx_scaled < 27'(whole));
                                amp_next    = psns_pkg::AMP_TABLE[6'(count_reg)];
                                state_next  = (count_reg == '0) ? psns_pkg::BK_OUT
                                                                : psns_pkg::BK_PHASE;
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            psns_pkg::BK_PHASE:
            begin
                mul_a    = psns_pkg::PHASE_RECIP;
                mul_b    = 16'(phase_reg[k_reg]);
                phase_wr = 1'b1;
                if (!silent_reg) begin
                    state_next = psns_pkg::BK_QUAD;
                end else if (last_voice) begin
                    state_next = psns_pkg::BK_OUT;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            psns_pkg::BK_QUAD:
            begin
                // Odd quadrants run the quarter wave backward.
                quad_next  = quot[16:15];
                z_next     = z_off;
                mul_a      = 25'(z_off);
                mul_b      = z_off;
                state_next = psns_pkg::BK_POLY1;
            end
            psns_pkg::BK_POLY1:
            begin
                z2_next    = p_reg[30:15];
                mul_a      = 25'd2320;
                mul_b      = p_reg[30:15];
                state_next = psns_pkg::BK_POLY2;
            end
            psns_pkg::BK_POLY2:
            begin
                t_val      = 16'd21024 - {4'd0, p_reg[26:15]};
                mul_a      = 25'(t_val);
                mul_b      = z2_reg;
                state_next = psns_pkg::BK_POLY3;
            end
            psns_pkg::BK_POLY3:
            begin
                t_val      = 16'd51472 - p_reg[30:15];
                mul_a      = 25'(t_val);
                mul_b      = z_reg;
                state_next = psns_pkg::BK_SCALE;
            end
            psns_pkg::BK_SCALE:
            begin
                mul_a      = 25'(amp_reg);
                mul_b      = (t_wide > 17'd32767) ? 16'd32767 : t_wide[15:0];
                state_next = psns_pkg::BK_ACC;
            end
            psns_pkg::BK_ACC:
            begin
                // Sign goes on after the scaling shift, so the result truncates
                // toward zero.
                sum_next = quad_reg[1] ? (sum_reg - {1'b0, mag}) : (sum_reg + {1'b0, mag});
                if (last_voice) begin
                    state_next = psns_pkg::BK_OUT;
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = psns_pkg::BK_PHASE;
                end
            end
            psns_pkg::BK_OUT:
            begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next    = 1'b1;
                    out_sample_next   = sum_reg;
                    out_end_next      = last_sample;
                    sample_index_next = sample_index_reg + LW'(1);
                    if (last_sample) begin
                        note_active_next = 1'b0;
                    end
                    state_next = psns_pkg::BK_IDLE;
                end
            end
            default: state_next = psns_pkg::BK_IDLE;
        endcase

        p_next = psns_pkg::PROD_W'(mul_a) * psns_pkg::PROD_W'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= psns_pkg::BK_IDLE;
            count_reg        <= '0;
            k_reg            <= '0;
            chord_open_reg   <= 1'b0;
            note_active_reg  <= 1'b0;
            sample_index_reg <= '0;
            note_samples_reg <= '0;
            pause_reg        <= 1'b0;
            silent_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            k_reg            <= k_next;
            chord_open_reg   <= chord_open_next;
            note_active_reg  <= note_active_next;
            sample_index_reg <= sample_index_next;
            note_samples_reg <= note_samples_next;
            pause_reg        <= pause_next;
            silent_reg       <= silent_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        amp_reg        <= amp_next;
        sum_reg        <= sum_next;
        p_reg          <= p_next;
        z_reg          <= z_next;
        z2_reg         <= z2_next;
        quad_reg       <= quad_next;
        out_sample_reg <= out_sample_next;
        out_end_reg    <= out_end_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_VOICES; i++) begin
                phase_reg[i] <= '0;
            end
        end else if (phase_clear) begin
            for (int i = 0; i < MAX_VOICES; i++) begin
                phase_reg[i] <= '0;
            end
        end else if (phase_wr) begin
            phase_reg[k_reg] <= phase_new;
        end
    end

    always_ff @(posedge clk) begin
        if (freq_wr) begin
            freq_mem[freq_addr] <= q_entry.freq;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/polyphonic_sine_note_synth.sv =====
// ---------------------------------------------------------------------------
// polyphonic_sine_note_synth
// Chord note synthesizer: key and start commands build notes, ticks emit
// summed sine samples.
// ---------------------------------------------------------------------------
// Commands enter through a two-entry queue, so the command channel keeps
// taking requests while the voice engine works and while a sample waits in
// the output register. An add-key or start command is handled in the idle
// state. For a tick, one shared 25x16 multiplier evaluates the phase
// scaling, the sine polynomial and the voice amplitude of each voice in
// turn; while the note head is silenced only the phase step runs. A tick
// with no note playing produces no sample. The whole-note length register
// sits at address 0.
`default_nettype none

module polyphonic_sine_note_synth #(
    parameter int MAX_VOICES = psns_pkg::MAX_VOICES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    psns_cmd_if.sink         cmd,
    psns_smp_if.source       smp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [psns_pkg::LEN_W-1:0] whole_reg, whole_next;
    logic                       push;
    psns_pkg::cmd_entry_t       push_entry;
    logic                       full;
    logic                       q_valid;
    logic                       q_pop;
    psns_pkg::cmd_entry_t       q_entry;
    logic [15:0]                sample_bits;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == psns_pkg::REG_WHOLE_NOTE) ? 32'(whole_reg) : 32'd0;

    always_comb begin
        whole_next = whole_reg;
        if (psel && penable && pwrite && (paddr[2] == psns_pkg::REG_WHOLE_NOTE)) begin
            whole_next = pwdata[psns_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            whole_reg <= psns_pkg::WHOLE_RESET;
        end else begin
            whole_reg <= whole_next;
        end
    end

    psns_front u_front (
        .cmd        (cmd),
        .whole      (whole_reg),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    psns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (q_pop),
        .valid      (q_valid),
        .entry      (q_entry)
    );

    psns_back #(
        .MAX_VOICES (MAX_VOICES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop),
        .whole      (whole_reg),
        .out_valid  (smp.valid),
        .out_ready  (smp.ready),
        .out_sample (sample_bits),
        .out_end    (smp.note_end)
    );

    assign smp.sample = $signed(sample_bits);

endmodule

`default_nettype wire

// ===== hw/rtl/psns_checker.sv =====
// ---------------------------------------------------------------------------
// psns_checker
// Port-level checks of the note synthesizer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "polyphonic_sine_note_synth_defines.svh"

module psns_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] sample,
    input wire logic        note_end,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    logic        out_wait;
    logic [16:0] out_word;
    logic        cfg_wr;
    logic [19:0] rd_len;
    logic [19:0] wr_len;

    assign out_wait = out_valid && !out_ready;
    assign out_word = {sample, note_end};
    assign cfg_wr   = psel && penable && pwrite && pready && !paddr[2];
    assign rd_len   = prdata[19:0];
    assign wr_len   = pwdata[19:0];

    // A sample that is not taken stays put.
    `PSNS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_word))

    // A length write reads back in the next cycle while the register is addressed.
    `PSNS_ASSERT_NEXT(a_cfg_readback, clk, rst_n, cfg_wr, paddr[2] || rd_len == $past(wr_len))

    // The upper read bits of the length register are always zero.
    `PSNS_ASSERT_ALWAYS(a_cfg_upper, clk, rst_n, prdata[31:20] == 12'd0)

endmodule

bind polyphonic_sine_note_synth psns_checker u_psns_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (smp.valid),
    .out_ready (smp.ready),
    .sample    (smp.sample),
    .note_end  (smp.note_end),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);

`default_nettype wire

// ===== dv/polyphonic_sine_note_synth_tb.sv =====
// ---------------------------------------------------------------------------
// polyphonic_sine_note_synth_tb
// Self-checking bench for the chord note synthesizer. A scoreboard class
// keeps its own copy of the chord, phase and note state and predicts every
// sample of each accepted tick request. Stimulus is a short directed pass,
// then random chords, notes and ticks under several whole-note lengths.
// The command channel idles at random and the sample channel stalls at random.
// ---------------------------------------------------------------------------
module polyphonic_sine_note_synth_tb;

    localparam logic [1:0] OP_NOISE   = 2'd3;
    localparam int         IDLE_LIMIT = 20000;
    localparam int         SETTLE     = 400;
    localparam int         ITEM_GOAL  = 1850;

    class note_scoreboard;
        logic [15:0] sample_q[$];
        logic        end_q[$];
        int          errors;
        logic [19:0] whole;
        logic [11:0] freq[psns_pkg::MAX_VOICES_DEF];
        logic [12:0] phase[psns_pkg::MAX_VOICES_DEF];
        int unsigned nvoice;
        logic        chord_open;
        logic        playing;
        logic        hush;
        logic [19:0] idx;
        logic [19:0] nsamp;

        function new();
            whole      = psns_pkg::WHOLE_RESET;
            nvoice     = 0;
            chord_open = 0;
            playing    = 0;
            hush       = 0;
            idx        = '0;
            nsamp      = '0;
            errors     = 0;
            foreach (phase[k])
            begin
                phase[k] = '0;
                freq[k]  = '0;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function int pending();
            return sample_q.size();
        endfunction

        function void set_whole(logic [19:0] v);
            whole = v;
        endfunction

        function int unsigned column_of(logic [7:0] letter);
            logic [7:0] c;
            c = letter;
            if (c >= "a" && c <= "z") c = c - 8'd32;
            case (c)
                "C": return 0;  "X": return 1;  "D": return 2;  "Y": return 3;
                "E": return 4;  "F": return 5;  "Z": return 6;  "G": return 7;
                "V": return 8;  "A": return 9;  "W": return 10; "B": return 11;
                "P": return 12; " ": return 11;
                default: return 0;
            endcase
        endfunction

        // Signed share of one voice, already wrapped to the sample width.
        function logic [15:0] voice_share(logic [12:0] p, int unsigned amp);
            longint unsigned q;
            logic [1:0]      quad;
            int unsigned     z, z2, t, mag;
            q    = (longint'(p) << 17) / psns_pkg::SAMPLE_RATE;
            quad = q[16:15];
            z    = int'(q & 64'h7fff);
            if (quad[0]) z = 32768 - z;
            z2 = (z * z) >> 15;
            t  = (2320 * z2) >> 15;
            t  = 21024 - t;
            t  = (t * z2) >> 15;
            t  = 51472 - t;
            t  = (t * z) >> 15;
            if (t > 32767) t = 32767;
            mag = (amp * t) >> 15;
            return quad[1] ? 16'(0 - mag) : 16'(mag);
        endfunction

        function void note_cmd(logic [1:0] op, logic [7:0] key, logic [7:0] oct,
                               logic [7:0] len, logic same);
            int unsigned row, amp;
            logic [31:0] w;
            logic [15:0] sum;
            logic        silent, last;
            w = 32'(whole);
            case (op)
                psns_pkg::OP_ADD_KEY:
                begin
                    if (playing) return;
                    if (!chord_open)
                    begin
                        nvoice     = 0;
                        chord_open = 1;
                    end
                    if (nvoice >= psns_pkg::MAX_VOICES_DEF) return;
                    row = (oct >= psns_pkg::CHAR_ONE && oct <= psns_pkg::CHAR_SEVEN)
                          ? oct - psns_pkg::CHAR_ONE : 0;
                    freq[nvoice] = psns_pkg::PITCH_GRID[row][column_of(key)];
                    nvoice++;
                end
                psns_pkg::OP_START:
                begin
                    case (len)
                        psns_pkg::CHAR_ONE:   nsamp = 20'(w);
                        psns_pkg::CHAR_TWO:   nsamp = 20'((w * 3) / 4);
                        psns_pkg::CHAR_THREE: nsamp = 20'(w / 2);
                        psns_pkg::CHAR_FOUR:  nsamp = 20'(w / 4);
                        psns_pkg::CHAR_FIVE:  nsamp = 20'(w / 8);
                        psns_pkg::CHAR_SIX:   nsamp = 20'(w / 16);
                        psns_pkg::CHAR_SEVEN: nsamp = 20'(w / 32);
                        psns_pkg::CHAR_EIGHT: nsamp = 20'(w / 64);
                        default: ;
                    endcase
                    hush       = same;
                    chord_open = 0;
                    idx        = '0;
                    foreach (phase[k]) phase[k] = '0;
                    playing = (nsamp != 0);
                end
                psns_pkg::OP_TICK:
                begin
                    if (!playing) return;
                    sum    = '0;
                    silent = hush && (32'(idx) * 125 < w);
                    amp    = (nvoice == 0) ? 0 : 32767 / nvoice;
                    for (int k = 0; k < nvoice; k++)
                    begin
                        if (!silent) sum = sum + voice_share(phase[k], amp);
                        phase[k] = 13'((32'(phase[k]) + 32'(freq[k]))
                                       % psns_pkg::SAMPLE_RATE);
                    end
                    last = (32'(idx) + 1) >= 32'(nsamp);
                    idx  = idx + 20'd1;
                    if (last) playing = 0;
                    sample_q.push_back(sum);
                    end_q.push_back(last);
                end
                default: ;
            endcase
        endfunction

        task check_result(logic [15:0] s, logic e);
            logic [15:0] want_s;
            logic        want_e;
            if (sample_q.size() == 0)
            begin
                report($sformatf("unexpected sample %h note_end %b", s, e));
                return;
            end
            want_s = sample_q.pop_front();
            want_e = end_q.pop_front();
            if (s !== want_s)
                report($sformatf("sample %h, expected %h", s, want_s));
            if (e !== want_e)
                report($sformatf("note_end %b, expected %b", e, want_e));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    psns_cmd_if cmd_if();
    psns_smp_if smp_if();

    polyphonic_sine_note_synth u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .smp     (smp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    note_scoreboard sb = new();

    int          items_sent;
    int          burst_left;
    bit          gaps_on;
    bit          hold_off;
    int          stall_mode;
    int          idle_cycles;
    longint      cyc;
    logic [19:0] cur_whole;
    logic [19:0] gen_len;
    string       key_set = "CXDYEFZGVAWBPcxdyefzgvawbp ";

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && cmd_if.valid && cmd_if.ready)
            sb.note_cmd(cmd_if.opcode, cmd_if.key_letter, cmd_if.octave_digit,
                        cmd_if.length_code, cmd_if.same_as_next);
        if (rst_n && smp_if.valid && smp_if.ready)
            sb.check_result(smp_if.sample, smp_if.note_end);
    end

    // The receiver switches at random between four stall patterns.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 3);
        if (hold_off) smp_if.ready <= 1'b0;
        else
        begin
            case (stall_mode)
                0:       smp_if.ready <= 1'b1;
                1:       smp_if.ready <= ($urandom_range(0, 3) != 0);
                2:       smp_if.ready <= ((cyc % 7) < 3);
                default: smp_if.ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (smp_if.valid && smp_if.ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task send_cmd(logic [1:0] op, logic [7:0] key, logic [7:0] oct,
                  logic [7:0] len, logic same);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on && $urandom_range(0, 3) != 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        cmd_if.valid        <= 1'b1;
        cmd_if.opcode       <= op;
        cmd_if.key_letter   <= key;
        cmd_if.octave_digit <= oct;
        cmd_if.length_code  <= len;
        cmd_if.same_as_next <= same;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        items_sent++;
    endtask

    task add_key(logic [7:0] key, logic [7:0] oct);
        send_cmd(psns_pkg::OP_ADD_KEY, key, oct, 8'($urandom), 1'($urandom));
    endtask

    task start_note(logic [7:0] len, logic same);
        send_cmd(psns_pkg::OP_START, 8'($urandom), 8'($urandom), len, same);
    endtask

    task tick();
        send_cmd(psns_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                 1'($urandom));
    endtask

    task drain();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_whole(logic [19:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(psns_pkg::REG_WHOLE_NOTE) << 2;
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_whole(v);
        cur_whole = v;
    endtask

    // One random note: a chord (or a replay), a start and its ticks, with
    // the odd stray request mixed in.
    task play_note(int cap);
        int          nkeys, nticks;
        logic [7:0]  len, key, oct;
        logic [31:0] w;
        w = 32'(cur_whole);
        if ($urandom_range(0, 9) == 0) nkeys = 0;
        else if ($urandom_range(0, 5) == 0) nkeys = $urandom_range(18, 23);
        else nkeys = $urandom_range(1, 6);
        for (int k = 0; k < nkeys; k++)
        begin
            key = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                              : key_set[$urandom_range(0, 26)];
            oct = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                              : psns_pkg::CHAR_ONE
                                                + 8'($urandom_range(0, 6));
            add_key(key, oct);
        end
        len = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                          : psns_pkg::CHAR_ONE + 8'($urandom_range(0, 7));
        case (len)
            psns_pkg::CHAR_ONE:   gen_len = 20'(w);
            psns_pkg::CHAR_TWO:   gen_len = 20'((w * 3) / 4);
            psns_pkg::CHAR_THREE: gen_len = 20'(w / 2);
            psns_pkg::CHAR_FOUR:  gen_len = 20'(w / 4);
            psns_pkg::CHAR_FIVE:  gen_len = 20'(w / 8);
            psns_pkg::CHAR_SIX:   gen_len = 20'(w / 16);
            psns_pkg::CHAR_SEVEN: gen_len = 20'(w / 32);
            psns_pkg::CHAR_EIGHT: gen_len = 20'(w / 64);
            default: ;
        endcase
        start_note(len, 1'($urandom));
        nticks = (32'(gen_len) < cap) ? int'(gen_len) : cap;
        if ($urandom_range(0, 7) == 0) nticks = $urandom_range(0, nticks);
        else if ($urandom_range(0, 3) == 0) nticks += $urandom_range(1, 2);
        for (int k = 0; k < nticks; k++)
        begin
            if ($urandom_range(0, 29) == 0) add_key(8'($urandom), 8'($urandom));
            if ($urandom_range(0, 39) == 0)
                send_cmd(OP_NOISE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            tick();
        end
    endtask

    task run_phase(logic [19:0] w, int goal, int cap);
        write_whole(w);
        gaps_on = ($urandom_range(0, 3) != 0);
        while (items_sent < goal) play_note(cap);
        drain();
    endtask

    initial
    begin
        logic [19:0] lens[6];
        rst_n               = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.opcode       = psns_pkg::OP_TICK;
        cmd_if.key_letter   = '0;
        cmd_if.octave_digit = '0;
        cmd_if.length_code  = '0;
        cmd_if.same_as_next = 1'b0;
        smp_if.ready        = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        hold_off            = 1'b0;
        stall_mode          = 0;
        cyc                 = 0;
        idle_cycles         = 0;
        items_sent          = 0;
        burst_left          = 0;
        gaps_on             = 1'b0;
        cur_whole           = psns_pkg::WHOLE_RESET;
        gen_len             = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass: stray tick, unknown opcode, empty chord, key decode
        // corners, rest, chord replay, silenced head, key during a note.
        write_whole(20'd64);
        tick();
        send_cmd(OP_NOISE, 8'hff, 8'hff, 8'hff, 1'b1);
        start_note(psns_pkg::CHAR_EIGHT, 1'b0);
        tick();
        add_key("c", psns_pkg::CHAR_ONE);
        add_key("X", psns_pkg::CHAR_SEVEN);
        add_key("p", psns_pkg::CHAR_FOUR);
        add_key(" ", 8'hff);
        add_key(8'h00, 8'h00);
        add_key("B", psns_pkg::CHAR_SEVEN);
        start_note(psns_pkg::CHAR_SEVEN, 1'b1);
        tick();
        add_key("A", psns_pkg::CHAR_FOUR);
        tick();
        start_note(8'h00, 1'b0);
        repeat (3) tick();
        start_note(psns_pkg::CHAR_EIGHT, 1'b0);
        tick();
        drain();

        // Zero-length note at the smallest whole note.
        write_whole(20'd1);
        add_key("G", psns_pkg::CHAR_FIVE);
        start_note(psns_pkg::CHAR_TWO, 1'b0);
        tick();
        start_note(psns_pkg::CHAR_ONE, 1'b1);
        tick();
        drain();

        lens = '{20'd64, 20'd1, 20'd300, 20'hfffff, 20'd32000, 20'd20};
        foreach (lens[p])
            run_phase(lens[p], (p + 1) * (ITEM_GOAL - 350) / 6, 60);

        // Long receiver hold-off while requests keep coming, so the command
        // queue fills and the input stalls.
        write_whole(20'd128);
        fork
            begin
                hold_off <= 1'b1;
                repeat (800) @(posedge clk);
                hold_off <= 1'b0;
            end
            begin
                gaps_on = 1'b0;
                repeat (4) play_note(60);
            end
        join
        drain();
        write_whole(psns_pkg::WHOLE_RESET);
        repeat (3) play_note(40);
        drain();

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/psns_pkg.sv
hw/rtl/psns_if.sv
hw/rtl/psns_front.sv
hw/rtl/psns_queue.sv
hw/rtl/psns_back.sv
hw/rtl/polyphonic_sine_note_synth.sv
hw/rtl/psns_checker.sv
dv/polyphonic_sine_note_synth_tb.sv
